### src/ilha_pkg.sv
`default_nettype none
package ilha_pkg;

   localparam int TAG_W      = 16;
   localparam int SIZE_W     = 15;
   localparam int ADDR_W     = 14;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 1;

   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'b1;

   localparam logic [SIZE_W-1:0] CHUNK_RESET = 15'd512;
   localparam logic [SIZE_W-1:0] LIMIT_RESET = 15'd16384;

   localparam logic [TAG_W-1:0] MIN_SPLIT = 16'd16;
   localparam logic [TAG_W-1:0] MIN_BLOCK = 16'd16;
   localparam logic [TAG_W-1:0] PROLOGUE  = 16'd9;
   localparam logic [TAG_W-1:0] EPILOGUE  = 16'd1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] result_addr;
      logic [SIZE_W-1:0] granted_size;
   } rsp_type;

   function automatic logic [TAG_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
      return {tag[TAG_W-1:3], 3'b000};
   endfunction

   function automatic logic [TAG_W-1:0] need_size(input logic [SIZE_W-1:0] req);
      logic [TAG_W-1:0] up;
      up = ({1'b0, req} + 16'd7) & 16'hFFF8;
      if (req <= 15'd8) begin
         return MIN_BLOCK;
      end
      return up + 16'd8;
   endfunction

endpackage
`default_nettype wire

### src/implicit_list_heap_allocator_top.sv
// Init writes the prologue and epilogue, then grows the heap; allocate walks the blocks first-fit and
// may split the block it takes, or grows the heap when none fits; free merges with free neighbours.
// Throughput: one item at a time; the tag RAM (one write, one registered read port) sets the pace.
// A finished response waits in an output register while the next request is taken.
// Reset: synchronous, clears break, initialized flag, registers to defaults; tag RAM is not cleared.
`default_nettype none
module implicit_list_heap_allocator_top #(
   parameter int HEAP_BYTES = 16384
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire ilha_pkg::req_type                       req_payload,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output ilha_pkg::rsp_type                            rsp_payload,
   input  wire logic                                    csr_write_en,
   input  wire logic [ilha_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [ilha_pkg::SIZE_W-1:0]             csr_wdata
);

   localparam int AW    = $clog2(HEAP_BYTES);
   localparam int DEPTH = HEAP_BYTES / 4;
   localparam int PW    = (AW > 18) ? AW : 18;

   localparam logic [5:0] ST_IDLE  = 6'd0;
   localparam logic [5:0] ST_INIT0 = 6'd1;
   localparam logic [5:0] ST_INIT1 = 6'd2;
   localparam logic [5:0] ST_INIT2 = 6'd3;
   localparam logic [5:0] ST_INIT3 = 6'd4;
   localparam logic [5:0] ST_GROW  = 6'd5;
   localparam logic [5:0] ST_GW1   = 6'd6;
   localparam logic [5:0] ST_GW2   = 6'd7;
   localparam logic [5:0] ST_GW3   = 6'd8;
   localparam logic [5:0] ST_MG0   = 6'd9;
   localparam logic [5:0] ST_MG1   = 6'd10;
   localparam logic [5:0] ST_MG2   = 6'd11;
   localparam logic [5:0] ST_MG3   = 6'd12;
   localparam logic [5:0] ST_MG4   = 6'd13;
   localparam logic [5:0] ST_MG5   = 6'd14;
   localparam logic [5:0] ST_MGA1  = 6'd15;
   localparam logic [5:0] ST_MGA2  = 6'd16;
   localparam logic [5:0] ST_MGB1  = 6'd17;
   localparam logic [5:0] ST_MGB2  = 6'd18;
   localparam logic [5:0] ST_MGB3  = 6'd19;
   localparam logic [5:0] ST_MGB4  = 6'd20;
   localparam logic [5:0] ST_MGB5  = 6'd21;
   localparam logic [5:0] ST_MGC1  = 6'd22;
   localparam logic [5:0] ST_MGC2  = 6'd23;
   localparam logic [5:0] ST_MGC3  = 6'd24;
   localparam logic [5:0] ST_MGC4  = 6'd25;
   localparam logic [5:0] ST_MRET  = 6'd26;
   localparam logic [5:0] ST_FF0   = 6'd27;
   localparam logic [5:0] ST_FF1   = 6'd28;
   localparam logic [5:0] ST_TK0   = 6'd29;
   localparam logic [5:0] ST_TK1   = 6'd30;
   localparam logic [5:0] ST_TK2   = 6'd31;
   localparam logic [5:0] ST_TK3   = 6'd32;
   localparam logic [5:0] ST_TK4   = 6'd33;
   localparam logic [5:0] ST_FR0   = 6'd34;
   localparam logic [5:0] ST_FR1   = 6'd35;
   localparam logic [5:0] ST_FR2   = 6'd36;
   localparam logic [5:0] ST_DONE  = 6'd37;

   logic [5:0]                   state_ff, state_in;
   logic [ilha_pkg::OP_W-1:0]    op_ff, op_in;
   logic [15:0]                  need_ff, need_in;
   logic [PW-1:0]                bp_ff, bp_in;
   logic [PW-1:0]                p_ff, p_in;
   logic [PW-1:0]                n_ff, n_in;
   logic [15:0]                  sb_ff, sb_in;
   logic [15:0]                  sp_ff, sp_in;
   logic [15:0]                  s_ff, s_in;
   logic                         pa_ff, pa_in;
   logic                         split_ff, split_in;
   logic [16:0]                  gs_ff, gs_in;
   logic [14:0]                  brk_ff, brk_in;
   logic                         init_ff, init_in;
   logic [ilha_pkg::SIZE_W-1:0]  chunk_ff, limit_ff;
   logic                         res_ok_ff, res_ok_in;
   logic [ilha_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [ilha_pkg::SIZE_W-1:0]  res_size_ff, res_size_in;
   logic                         rsp_valid_ff;
   ilha_pkg::rsp_type            rsp_ff;

   logic                         ram_we;
   logic [PW-1:0]                ram_wa, ram_ra;
   logic [15:0]                  ram_wd, ram_rdata;

   logic [15:0]                  rd_sz16;
   logic [PW-1:0]                rd_sz;
   logic [14:0]                  lim;
   logic [15:0]                  gbytes;
   logic [14:0]                  gwords;
   logic [16:0]                  gsize;
   logic [15:0]                  tk_rest;
   logic                         tk_split;
   logic [15:0]                  tk_grant;
   logic                         rsp_load;

   ilha_ram #(
      .WIDTH(16),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_wa[AW-1:2]),
      .wdata(ram_wd),
      .raddr(ram_ra[AW-1:2]),
      .rdata(ram_rdata)
   );

   assign rd_sz16 = ilha_pkg::tag_size(ram_rdata);
   assign rd_sz   = PW'(rd_sz16);
   assign lim     = (32'(limit_ff) < HEAP_BYTES) ? limit_ff : 15'(HEAP_BYTES);
   assign gbytes  = (op_ff == ilha_pkg::OP_INIT) ? {1'b0, chunk_ff} :
                    ((need_ff > {1'b0, chunk_ff}) ? need_ff : {1'b0, chunk_ff});
   assign gwords  = {1'b0, gbytes[15:2]} + {14'd0, gbytes[2]};
   assign gsize   = (gwords == '0) ? 17'd8 : {gwords, 2'b00};
   assign tk_rest = rd_sz16 - need_ff;
   assign tk_split = (rd_sz16 < need_ff) || (tk_rest >= ilha_pkg::MIN_SPLIT);
   assign tk_grant = tk_split ? need_ff : rd_sz16;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      need_in     = need_ff;
      bp_in       = bp_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      sb_in       = sb_ff;
      sp_in       = sp_ff;
      s_in        = s_ff;
      pa_in       = pa_ff;
      split_in    = split_ff;
      gs_in       = gs_ff;
      brk_in      = brk_ff;
      init_in     = init_ff;
      res_ok_in   = res_ok_ff;
      res_addr_in = res_addr_ff;
      res_size_in = res_size_ff;
      ram_we      = 1'b0;
      ram_wa      = '0;
      ram_wd      = '0;
      ram_ra      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_payload.op;
               need_in     = ilha_pkg::need_size(req_payload.req_size);
               res_ok_in   = 1'b0;
               res_addr_in = '0;
               res_size_in = '0;
               state_in    = ST_DONE;
               unique case (req_payload.op)
                  ilha_pkg::OP_INIT: begin
                     init_in = 1'b0;
                     brk_in  = '0;
                     if (lim >= 15'd16) begin
                        state_in = ST_INIT0;
                     end
                  end
                  ilha_pkg::OP_ALLOC: begin
                     if (init_ff && req_payload.req_size != '0) begin
                        bp_in    = PW'(8);
                        state_in = ST_FF0;
                     end
                  end
                  ilha_pkg::OP_FREE: begin
                     if (init_ff) begin
                        bp_in    = PW'(req_payload.block_addr);
                        state_in = ST_FR0;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_INIT0: begin
            ram_we   = 1'b1;
            ram_wa   = PW'(0);
            ram_wd   = '0;
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            ram_we   = 1'b1;
            ram_wa   = PW'(4);
            ram_wd   = ilha_pkg::PROLOGUE;
            state_in = ST_INIT2;
         end
         ST_INIT2: begin
            ram_we   = 1'b1;
            ram_wa   = PW'(8);
            ram_wd   = ilha_pkg::PROLOGUE;
            state_in = ST_INIT3;
         end
         ST_INIT3: begin
            ram_we   = 1'b1;
            ram_wa   = PW'(12);
            ram_wd   = ilha_pkg::EPILOGUE;
            brk_in   = 15'd16;
            state_in = ST_GROW;
         end
         ST_GROW: begin
            if (18'(brk_ff) + 18'(gsize) > 18'(lim)) begin
               res_ok_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               bp_in    = PW'(brk_ff);
               gs_in    = gsize;
               brk_in   = 15'(18'(brk_ff) + 18'(gsize));
               state_in = ST_GW1;
            end
         end
         ST_GW1: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff - PW'(4);
            ram_wd   = gs_ff[15:0];
            state_in = ST_GW2;
         end
         ST_GW2: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(gs_ff) - PW'(8);
            ram_wd   = gs_ff[15:0];
            state_in = ST_GW3;
         end
         ST_GW3: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(gs_ff) - PW'(4);
            ram_wd   = ilha_pkg::EPILOGUE;
            state_in = ST_MG0;
         end
         ST_MG0: begin
            ram_ra   = bp_ff - PW'(8);
            state_in = ST_MG1;
         end
         ST_MG1: begin
            p_in     = bp_ff - rd_sz;
            ram_ra   = bp_ff - rd_sz - PW'(4);
            state_in = ST_MG2;
         end
         ST_MG2: begin
            sp_in    = rd_sz16;
            ram_ra   = p_ff + rd_sz - PW'(8);
            state_in = ST_MG3;
         end
         ST_MG3: begin
            pa_in    = ram_rdata[0];
            ram_ra   = bp_ff - PW'(4);
            state_in = ST_MG4;
         end
         ST_MG4: begin
            sb_in    = rd_sz16;
            n_in     = bp_ff + rd_sz;
            ram_ra   = bp_ff + rd_sz - PW'(4);
            state_in = ST_MG5;
         end
         ST_MG5: begin
            priority if (pa_ff && ram_rdata[0]) begin
               state_in = ST_MRET;
            end else if (pa_ff) begin
               s_in     = sb_ff + rd_sz16;
               state_in = ST_MGA1;
            end else if (ram_rdata[0]) begin
               s_in     = sb_ff + sp_ff;
               state_in = ST_MGB1;
            end else begin
               ram_ra   = n_ff + rd_sz - PW'(8);
               state_in = ST_MGC1;
            end
         end
         ST_MGA1: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff - PW'(4);
            ram_wd   = s_ff;
            state_in = ST_MGA2;
         end
         ST_MGA2: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(ilha_pkg::tag_size(s_ff)) - PW'(8);
            ram_wd   = s_ff;
            state_in = ST_MRET;
         end
         ST_MGB1: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(sb_ff) - PW'(8);
            ram_wd   = s_ff;
            state_in = ST_MGB2;
         end
         ST_MGB2: begin
            ram_ra   = bp_ff - PW'(8);
            state_in = ST_MGB3;
         end
         ST_MGB3: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff - rd_sz - PW'(4);
            ram_wd   = s_ff;
            state_in = ST_MGB4;
         end
         ST_MGB4: begin
            ram_ra   = bp_ff - PW'(8);
            state_in = ST_MGB5;
         end
         ST_MGB5: begin
            bp_in    = bp_ff - rd_sz;
            state_in = ST_MRET;
         end
         ST_MGC1: begin
            s_in     = sb_ff + sp_ff + rd_sz16;
            ram_we   = 1'b1;
            ram_wa   = p_ff - PW'(4);
            ram_wd   = sb_ff + sp_ff + rd_sz16;
            state_in = ST_MGC2;
         end
         ST_MGC2: begin
            ram_ra   = bp_ff - PW'(4);
            state_in = ST_MGC3;
         end
         ST_MGC3: begin
            n_in     = bp_ff + rd_sz;
            ram_ra   = bp_ff + rd_sz - PW'(4);
            state_in = ST_MGC4;
         end
         ST_MGC4: begin
            ram_we   = 1'b1;
            ram_wa   = n_ff + rd_sz - PW'(8);
            ram_wd   = s_ff;
            state_in = ST_MGB4;
         end
         ST_MRET: begin
            state_in = ST_DONE;
            unique case (op_ff)
               ilha_pkg::OP_INIT: begin
                  res_ok_in = (bp_ff != '0);
                  init_in   = (bp_ff != '0);
               end
               ilha_pkg::OP_ALLOC: begin
                  if (bp_ff != '0) begin
                     state_in = ST_TK0;
                  end
               end
               ilha_pkg::OP_FREE: begin
                  res_ok_in = 1'b1;
               end
               default: begin
                  res_ok_in = 1'b0;
               end
            endcase
         end
         ST_FF0: begin
            if ((bp_ff - PW'(4)) >= PW'(brk_ff)) begin
               state_in = ST_GROW;
            end else begin
               ram_ra   = bp_ff - PW'(4);
               state_in = ST_FF1;
            end
         end
         ST_FF1: begin
            priority if (!ram_rdata[0] && rd_sz16 >= need_ff) begin
               state_in = ST_TK0;
            end else if (rd_sz16 == '0) begin
               state_in = ST_GROW;
            end else begin
               bp_in    = bp_ff + rd_sz;
               state_in = ST_FF0;
            end
         end
         ST_TK0: begin
            ram_ra   = bp_ff - PW'(4);
            state_in = ST_TK1;
         end
         ST_TK1: begin
            sb_in       = rd_sz16;
            s_in        = tk_rest;
            split_in    = tk_split;
            ram_we      = 1'b1;
            ram_wa      = bp_ff - PW'(4);
            ram_wd      = tk_grant | 16'd1;
            res_ok_in   = 1'b1;
            res_addr_in = bp_ff[ilha_pkg::ADDR_W-1:0];
            res_size_in = tk_grant[ilha_pkg::SIZE_W-1:0];
            state_in    = ST_TK2;
         end
         ST_TK2: begin
            ram_we = 1'b1;
            if (split_ff) begin
               ram_wa   = bp_ff + PW'(need_ff) - PW'(8);
               ram_wd   = need_ff | 16'd1;
               state_in = ST_TK3;
            end else begin
               ram_wa   = bp_ff + PW'(sb_ff) - PW'(8);
               ram_wd   = sb_ff | 16'd1;
               state_in = ST_DONE;
            end
         end
         ST_TK3: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(need_ff) - PW'(4);
            ram_wd   = s_ff;
            state_in = ST_TK4;
         end
         ST_TK4: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(sb_ff) - PW'(8);
            ram_wd   = s_ff;
            state_in = ST_DONE;
         end
         ST_FR0: begin
            ram_ra   = bp_ff - PW'(4);
            state_in = ST_FR1;
         end
         ST_FR1: begin
            sb_in    = rd_sz16;
            ram_we   = 1'b1;
            ram_wa   = bp_ff - PW'(4);
            ram_wd   = rd_sz16;
            state_in = ST_FR2;
         end
         ST_FR2: begin
            ram_we   = 1'b1;
            ram_wa   = bp_ff + PW'(sb_ff) - PW'(8);
            ram_wd   = sb_ff;
            state_in = ST_MG0;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         brk_ff       <= '0;
         init_ff      <= 1'b0;
         chunk_ff     <= ilha_pkg::CHUNK_RESET;
         limit_ff     <= ilha_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
         init_ff  <= init_in;
         if (csr_write_en) begin
            unique case (csr_index)
               ilha_pkg::CSR_CHUNK: chunk_ff <= csr_wdata;
               ilha_pkg::CSR_LIMIT: limit_ff <= csr_wdata;
               default: chunk_ff <= chunk_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      need_ff     <= need_in;
      bp_ff       <= bp_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      sb_ff       <= sb_in;
      sp_ff       <= sp_in;
      s_ff        <= s_in;
      pa_ff       <= pa_in;
      split_ff    <= split_in;
      gs_ff       <= gs_in;
      res_ok_ff   <= res_ok_in;
      res_addr_ff <= res_addr_in;
      res_size_ff <= res_size_in;
      if (rsp_load) begin
         rsp_ff.ok           <= res_ok_ff;
         rsp_ff.result_addr  <= res_addr_ff;
         rsp_ff.granted_size <= res_size_ff;
      end
   end

   a_brk_in_heap: assert property (@(posedge clock) disable iff (reset)
      32'(brk_ff) <= HEAP_BYTES)
      else $error("heap break beyond heap");

   a_init_has_heap: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> brk_ff >= 15'd24)
      else $error("initialized heap without grown chunk");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("transfer accepted without starting work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside completion");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff != ST_IDLE && state_ff != ST_DONE)
      else $error("tag write while idle");

endmodule
`default_nettype wire

### src/ilha_ram.sv
`default_nettype none
module ilha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### bench/ilha_checker.sv
`timescale 1ns / 1ps
module ilha_checker
   import ilha_pkg::*;
#(
   parameter int HEAP_BYTES = 16384
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_payload,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata,
   output int                        errors,
   output int                        waiting
);

   localparam int WORDS = HEAP_BYTES / 4;

   logic [TAG_W-1:0] tags [WORDS];
   int unsigned      brk;
   bit               heap_ready;
   int unsigned      chunk;
   int unsigned      limit;
   rsp_type          outcome_q[$];

   function automatic int unsigned rd(input int unsigned a);
      return tags[(a >> 2) % WORDS];
   endfunction

   function automatic void wr(input int unsigned a, input int unsigned v);
      tags[(a >> 2) % WORDS] = v[TAG_W-1:0];
   endfunction

   function automatic int unsigned tsz(input int unsigned a);
      return rd(a) & 32'hFFF8;
   endfunction

   function automatic int unsigned tal(input int unsigned a);
      return rd(a) & 32'h1;
   endfunction

   function automatic int unsigned bsz(input int unsigned bp);
      return tsz(bp - 4);
   endfunction

   function automatic int unsigned ftr(input int unsigned bp);
      return bp + bsz(bp) - 8;
   endfunction

   function automatic int unsigned nxt(input int unsigned bp);
      return bp + bsz(bp);
   endfunction

   function automatic int unsigned prv(input int unsigned bp);
      return bp - tsz(bp - 8);
   endfunction

   function automatic int unsigned cap();
      return (limit < HEAP_BYTES) ? limit : HEAP_BYTES;
   endfunction

   function automatic int unsigned coalesce(input int unsigned bp);
      int unsigned pa, na, s;
      pa = tal(ftr(prv(bp)));
      na = tal(nxt(bp) - 4);
      s  = bsz(bp);
      if (pa != 0 && na != 0) begin
         return bp;
      end
      if (pa != 0) begin
         s += bsz(nxt(bp));
         wr(bp - 4, s);
         wr(ftr(bp), s);
      end else if (na != 0) begin
         s += bsz(prv(bp));
         wr(ftr(bp), s);
         wr(prv(bp) - 4, s);
         bp = prv(bp);
      end else begin
         s += bsz(prv(bp)) + tsz(ftr(nxt(bp)));
         wr(prv(bp) - 4, s);
         wr(ftr(nxt(bp)), s);
         bp = prv(bp);
      end
      return bp;
   endfunction

   function automatic int unsigned extend(input int unsigned bytes);
      int unsigned w, s, bp;
      w = bytes >> 2;
      if (w[0]) begin
         w++;
      end
      s = w * 4;
      if (s == 0) begin
         s = 8;
      end
      if (brk + s > cap()) begin
         return 0;
      end
      bp = brk;
      brk += s;
      wr(bp - 4, s);
      wr(bp + s - 8, s);
      wr(bp + s - 4, 1);
      return coalesce(bp);
   endfunction

   function automatic int unsigned first_fit(input int unsigned need);
      int unsigned bp, s;
      bp = 8;
      for (int i = 0; i <= WORDS; i++) begin
         if (bp - 4 >= brk) begin
            return 0;
         end
         s = bsz(bp);
         if (tal(bp - 4) == 0 && s >= need) begin
            return bp;
         end
         if (s == 0) begin
            return 0;
         end
         bp += s;
      end
      return 0;
   endfunction

   function automatic int unsigned carve(input int unsigned bp, input int unsigned need);
      int unsigned s, rest;
      s    = bsz(bp);
      rest = s - need;
      if (rest >= 16) begin
         wr(bp - 4, need | 1);
         wr(bp + need - 8, need | 1);
         wr(bp + need - 4, rest);
         wr(bp + s - 8, rest);
         return need;
      end
      wr(bp - 4, s | 1);
      wr(bp + s - 8, s | 1);
      return s;
   endfunction

   function automatic rsp_type heap_outcome(input req_type r);
      rsp_type     o;
      int unsigned need, bp, s, req, addr;
      o    = '0;
      req  = r.req_size;
      addr = r.block_addr;
      case (r.op)
         OP_INIT: begin
            heap_ready = 0;
            brk        = 0;
            if (cap() >= 16) begin
               wr(0, 0);
               wr(4, 9);
               wr(8, 9);
               wr(12, 1);
               brk = 16;
               if (extend(chunk) != 0) begin
                  heap_ready = 1;
                  o.ok       = 1'b1;
               end
            end
         end
         OP_ALLOC: begin
            if (heap_ready && req != 0) begin
               need = (req <= 8) ? 16 : 8 + ((req + 7) & ~32'h7);
               bp   = first_fit(need);
               if (bp == 0) begin
                  bp = extend((need > chunk) ? need : chunk);
               end
               if (bp != 0) begin
                  s              = carve(bp, need);
                  o.ok           = 1'b1;
                  o.result_addr  = bp[ADDR_W-1:0];
                  o.granted_size = s[SIZE_W-1:0];
               end
            end
         end
         OP_FREE: begin
            if (heap_ready) begin
               s = bsz(addr);
               wr(addr - 4, s);
               wr(ftr(addr), s);
               void'(coalesce(addr));
               o.ok = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   assign waiting = outcome_q.size();

   initial begin
      errors = 0;
      for (int i = 0; i < WORDS; i++) begin
         tags[i] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         brk        = 0;
         heap_ready = 0;
         chunk      = CHUNK_RESET;
         limit      = LIMIT_RESET;
         outcome_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_CHUNK) begin
               chunk = csr_wdata;
            end else if (csr_index == CSR_LIMIT) begin
               limit = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer ok=%0d addr=%0d size=%0d", $time,
                        rsp_payload.ok, rsp_payload.result_addr, rsp_payload.granted_size);
            end else begin
               want = outcome_q.pop_front();
               if (want.ok !== rsp_payload.ok || want.result_addr !== rsp_payload.result_addr
                   || want.granted_size !== rsp_payload.granted_size) begin
                  errors++;
                  $display("%0t: mismatch expected ok=%0d addr=%0d size=%0d, got ok=%0d addr=%0d size=%0d",
                           $time, want.ok, want.result_addr, want.granted_size,
                           rsp_payload.ok, rsp_payload.result_addr, rsp_payload.granted_size);
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(heap_outcome(req_payload));
         end
      end
   end

endmodule

### bench/implicit_list_heap_allocator_top_tb.sv
`timescale 1ns / 1ps
module implicit_list_heap_allocator_top_tb;
   import ilha_pkg::*;

   localparam logic [OP_W-1:0] OP_BAD = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHUNK;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   int   errors, waiting;
   int   issued = 0, received = 0, grants = 0, refusals = 0;
   bit   quiet = 0, calm = 0;
   int   stall_left = 0;
   logic [ADDR_W-1:0] live_blocks[$];

   implicit_list_heap_allocator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ilha_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .waiting(waiting)
   );

   always #1 clock = ~clock;

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (rsp_payload.ok && rsp_payload.granted_size != 0) begin
            grants++;
            live_blocks.push_back(rsp_payload.result_addr);
         end else if (!rsp_payload.ok) begin
            refusals++;
         end
      end
   end

   task automatic send(input logic [OP_W-1:0] op, input int size, input int addr);
      req_type p;
      int      gap;
      p.op         = op;
      p.req_size   = size[SIZE_W-1:0];
      p.block_addr = addr[ADDR_W-1:0];
      gap = 0;
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (issued != received) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value[SIZE_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic release_live(input int idx);
      logic [ADDR_W-1:0] a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      send(OP_FREE, $urandom_range(0, 32767), a);
   endtask

   task automatic fresh_heap();
      drain();
      live_blocks.delete();
      send(OP_INIT, $urandom_range(0, 32767), $urandom_range(0, 16383));
      drain();
   endtask

   initial begin
      int chunks[5];
      int limits[5];
      int r, sz;
      chunks = '{512, 8, 64, 4096, 1000};
      limits = '{16384, 16384, 2048, 16384, 300};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(OP_ALLOC, 16, 0);
      send(OP_FREE, 0, 16383);
      send(OP_BAD, 32767, 16383);
      fresh_heap();
      send(OP_ALLOC, 1, 0);
      send(OP_ALLOC, 8, 0);
      send(OP_ALLOC, 9, 0);
      send(OP_ALLOC, 0, 0);
      send(OP_ALLOC, 32767, 0);
      send(OP_ALLOC, 16384, 0);
      send(OP_BAD, 0, 0);
      send(OP_ALLOC, 700, 0);
      drain();
      release_live(0);
      release_live(1);
      release_live(0);
      drain();
      release_live(live_blocks.size() - 1);

      drain();
      csr_write(CSR_CHUNK, 8);
      csr_write(CSR_LIMIT, 32);
      fresh_heap();
      send(OP_ALLOC, 1, 0);
      drain();
      csr_write(CSR_CHUNK, 16384);
      csr_write(CSR_LIMIT, 16384);
      fresh_heap();
      send(OP_ALLOC, 4, 0);
      drain();
      csr_write(CSR_LIMIT, 8);
      fresh_heap();
      send(OP_FREE, 0, 100);

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         csr_write(CSR_CHUNK, chunks[ph]);
         csr_write(CSR_LIMIT, limits[ph]);
         quiet = (ph == 4);
         fresh_heap();
         for (int n = 0; n < 290; n++) begin
            if (n % 40 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
               fresh_heap();
            end else if (r < 4) begin
               send(OP_BAD, $urandom_range(0, 32767), $urandom_range(0, 16383));
            end else if (r < 8) begin
               sz = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(8000, 32767);
               send(OP_ALLOC, sz, $urandom_range(0, 16383));
            end else if (r < 55 || live_blocks.size() == 0) begin
               case ($urandom_range(0, 9))
                  0:       sz = $urandom_range(1, 8);
                  1:       sz = $urandom_range(500, 4000);
                  default: sz = $urandom_range(1, 200);
               endcase
               send(OP_ALLOC, sz, $urandom_range(0, 16383));
            end else begin
               release_live($urandom_range(0, live_blocks.size() - 1));
            end
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d transfers: %0d blocks granted, %0d refused requests,", issued,
               grants, refusals);
      $display("five chunk and limit settings plus tiny-heap and failed-init cases.");
      if (errors == 0 && waiting == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
